FILE: rtl/core/akt_pkg.sv
// ----------------------------------------------------------------------------
// akt_pkg: shared types and constants of the aging key table
// Request and response payloads, table entry layout, cell operation codes.
// ----------------------------------------------------------------------------
package akt_pkg;

    // field widths
    localparam int KeyWidth   = 8;
    localparam int AgeWidth   = 16;
    localparam int FuncWidth  = 2;

    // at most this many responses per request
    localparam int MaxResults = 32;
    localparam int CntWidth   = $clog2(MaxResults + 1);

    // operation codes of a request
    localparam logic [FuncWidth-1:0] FuncAdd    = 2'd0;
    localparam logic [FuncWidth-1:0] FuncRemove = 2'd1;
    localparam logic [FuncWidth-1:0] FuncTick   = 2'd2;

    // indicator commands
    localparam logic LedOff   = 1'b0;
    localparam logic LedBlink = 1'b1;

    // cell operations, broadcast along the chain
    localparam logic [1:0] CellHold   = 2'd0;
    localparam logic [1:0] CellShift  = 2'd1;
    localparam logic [1:0] CellAppend = 2'd2;

    // register file
    localparam int                   PaddrWidth    = 3;
    localparam int                   DataWidth     = 32;
    localparam logic                 RegAgeLimit   = 1'b0;
    localparam logic [AgeWidth-1:0]  AgeLimitReset = 16'd60;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic [KeyWidth-1:0]  key;
    } req_t;

    typedef struct packed {
        logic [KeyWidth-1:0] led_key;
        logic                led_command;
        logic                found;
        logic                dropped;
        logic                last;
    } rsp_t;

    // one table entry; done marks an entry already visited in the current sweep
    typedef struct packed {
        logic                valid;
        logic                done;
        logic [KeyWidth-1:0] key;
        logic [AgeWidth-1:0] age;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     ins;
    } chain_ctl_t;

endpackage

FILE: rtl/core/akt_cell.sv
// ----------------------------------------------------------------------------
// akt_cell: one slot of the key table
// Holds one entry, pulls from its right neighbor on a shift, and takes the
// broadcast entry as the last occupied slot on a shift, first free on append.
// ----------------------------------------------------------------------------
module akt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  akt_pkg::chain_ctl_t ctl,
    input  akt_pkg::entry_t     right,
    input  logic               left_valid,
    output akt_pkg::entry_t     ent
);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          done_reg;
    logic                          done_next;
    logic [akt_pkg::KeyWidth-1:0]  key_reg;
    logic [akt_pkg::KeyWidth-1:0]  key_next;
    logic [akt_pkg::AgeWidth-1:0]  age_reg;
    logic [akt_pkg::AgeWidth-1:0]  age_next;

    // next entry of this slot
    always_comb
    begin
        valid_next = valid_reg;
        done_next  = done_reg;
        key_next   = key_reg;
        age_next   = age_reg;
        case (ctl.op)
            akt_pkg::CellShift:
            begin
                if (right.valid)
                begin
                    valid_next = right.valid;
                    done_next  = right.done;
                    key_next   = right.key;
                    age_next   = right.age;
                end
                else if (valid_reg)
                begin
                    // last occupied slot before the pop: write-back lands here
                    valid_next = ctl.ins.valid;
                    done_next  = ctl.ins.done & ctl.ins.valid;
                    key_next   = ctl.ins.key;
                    age_next   = ctl.ins.age;
                end
                else
                begin
                    valid_next = 1'b0;
                    done_next  = 1'b0;
                end
            end
            akt_pkg::CellAppend:
            begin
                done_next = 1'b0;
                if (!valid_reg && left_valid)
                begin
                    valid_next = ctl.ins.valid;
                    key_next   = ctl.ins.key;
                    age_next   = ctl.ins.age;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // payload bits
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        age_reg <= age_next;
    end

    assign ent.valid = valid_reg;
    assign ent.done  = done_reg;
    assign ent.key   = key_reg;
    assign ent.age   = age_reg;

endmodule

FILE: rtl/core/akt_ctrl.sv
// ----------------------------------------------------------------------------
// akt_ctrl: sweep sequencer of the key table
// Takes a request, walks the table through the head of the cell chain,
// writes entries back behind the unvisited ones and builds the responses.
// ----------------------------------------------------------------------------
module akt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [akt_pkg::AgeWidth-1:0]  age_limit,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  akt_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output akt_pkg::rsp_t                 rsp_data,
    input  akt_pkg::entry_t               head,
    input  logic                          full,
    output akt_pkg::chain_ctl_t           ctl
);

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StSweep  = 2'd1;
    localparam logic [1:0] StFinish = 2'd2;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [akt_pkg::FuncWidth-1:0]   func_reg;
    logic [akt_pkg::FuncWidth-1:0]   func_next;
    logic [akt_pkg::KeyWidth-1:0]    key_reg;
    logic [akt_pkg::KeyWidth-1:0]    key_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic [akt_pkg::CntWidth-1:0]    cnt_reg;
    logic [akt_pkg::CntWidth-1:0]    cnt_next;
    logic                            pend_valid_reg;
    logic                            pend_valid_next;
    logic [akt_pkg::KeyWidth-1:0]    pend_key_reg;
    logic [akt_pkg::KeyWidth-1:0]    pend_key_next;
    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    akt_pkg::rsp_t                   rsp_reg;
    akt_pkg::rsp_t                   rsp_next;
    logic                            out_free;
    logic                            head_live;
    logic                            match;
    logic                            load_rsp;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign head_live = head.valid && !head.done;
    assign match     = (head.key == key_reg);
    assign req_ready = (state_reg == StIdle);

    // sequencer and head processing
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        hit_next        = hit_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        load_rsp        = 1'b0;
        rsp_next        = rsp_reg;
        ctl.op          = akt_pkg::CellHold;
        ctl.ins         = '0;

        unique case (state_reg)
            StIdle:
            begin
                if (req_valid)
                begin
                    func_next       = req_data.func;
                    key_next        = req_data.key;
                    hit_next        = 1'b0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    priority if (req_data.func == akt_pkg::FuncAdd)
                    begin
                        if (req_data.key != '0)
                        begin
                            state_next = StSweep;
                        end
                    end
                    else if (req_data.func == akt_pkg::FuncRemove ||
                             req_data.func == akt_pkg::FuncTick)
                    begin
                        state_next = StSweep;
                    end
                    else
                    begin
                        state_next = StIdle;
                    end
                end
            end

            StSweep:
            begin
                if (!head_live)
                begin
                    state_next = StFinish;
                end
                else if (out_free)
                begin
                    // pop the head and write it back behind the unvisited entries
                    ctl.op        = akt_pkg::CellShift;
                    ctl.ins.valid = 1'b1;
                    ctl.ins.done  = 1'b1;
                    ctl.ins.key   = head.key;
                    ctl.ins.age   = head.age;
                    case (func_reg)
                        akt_pkg::FuncAdd:
                        begin
                            hit_next = hit_reg | match;
                        end
                        akt_pkg::FuncRemove:
                        begin
                            if (match && !hit_reg)
                            begin
                                ctl.ins.valid = 1'b0;
                                hit_next      = 1'b1;
                            end
                        end
                        akt_pkg::FuncTick:
                        begin
                            if (head.age < age_limit)
                            begin
                                ctl.ins.age = head.age + 16'd1;
                            end
                            else if (cnt_reg < akt_pkg::CntWidth'(akt_pkg::MaxResults))
                            begin
                                // expired: free it, hold its off command until
                                // we know whether another one follows
                                ctl.ins.valid   = 1'b0;
                                cnt_next        = cnt_reg + 1'b1;
                                pend_valid_next = 1'b1;
                                pend_key_next   = head.key;
                                if (pend_valid_reg)
                                begin
                                    load_rsp             = 1'b1;
                                    rsp_next.led_key     = pend_key_reg;
                                    rsp_next.led_command = akt_pkg::LedOff;
                                    rsp_next.found       = 1'b0;
                                    rsp_next.dropped     = 1'b0;
                                    rsp_next.last        = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            hit_next = hit_reg;
                        end
                    endcase
                end
            end

            StFinish:
            begin
                if (out_free)
                begin
                    // clear visit marks, append a new key at the first free slot
                    ctl.op        = akt_pkg::CellAppend;
                    ctl.ins.valid = (func_reg == akt_pkg::FuncAdd) && !hit_reg && !full;
                    ctl.ins.done  = 1'b0;
                    ctl.ins.key   = key_reg;
                    ctl.ins.age   = '0;
                    state_next    = StIdle;
                    case (func_reg)
                        akt_pkg::FuncAdd:
                        begin
                            load_rsp             = 1'b1;
                            rsp_next.led_key     = key_reg;
                            rsp_next.led_command = akt_pkg::LedBlink;
                            rsp_next.found       = 1'b0;
                            rsp_next.dropped     = !hit_reg && full;
                            rsp_next.last        = 1'b1;
                        end
                        akt_pkg::FuncRemove:
                        begin
                            load_rsp             = 1'b1;
                            rsp_next.led_key     = key_reg;
                            rsp_next.led_command = akt_pkg::LedOff;
                            rsp_next.found       = hit_reg;
                            rsp_next.dropped     = 1'b0;
                            rsp_next.last        = 1'b1;
                        end
                        akt_pkg::FuncTick:
                        begin
                            if (pend_valid_reg)
                            begin
                                load_rsp             = 1'b1;
                                rsp_next.led_key     = pend_key_reg;
                                rsp_next.led_command = akt_pkg::LedOff;
                                rsp_next.found       = 1'b0;
                                rsp_next.dropped     = 1'b0;
                                rsp_next.last        = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_rsp = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    // response register
    always_comb
    begin
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= StIdle;
            hit_reg        <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hit_reg        <= hit_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        pend_key_reg <= pend_key_next;
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

FILE: rtl/core/aging_key_table_with_led_core.sv
// ----------------------------------------------------------------------------
// aging_key_table_with_led_core: aging key table with indicator commands
// Keeps up to CAPACITY keys with age counters and issues blink/off commands.
// ----------------------------------------------------------------------------
// Usage
// - request channel (req_valid/req_ready/req_data): func add, remove or tick
//   plus a key. A request is taken only while no other request is in work.
// - response channel (rsp_valid/rsp_ready/rsp_data): indicator commands; last
//   marks the final one of a request. An add gives one blink command (none for
//   key zero), a remove one off command, a tick one off command per expiry.
// - the table lives in a row of CAPACITY cells. A request sweeps the valid
//   entries past the head cell, one entry per cycle unless the response
//   register is stalled.
// - responses sit in an output register; while it is stalled the sweep holds
//   at the head entry, and nothing is lost.
// - age_limit sits at byte address 0 of the APB port, 60 after reset; write it
//   only while no request is in work.
// - reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module aging_key_table_with_led_core #(
    parameter int CAPACITY = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [akt_pkg::PaddrWidth-1:0]   paddr,
    input  logic [akt_pkg::DataWidth-1:0]    pwdata,
    output logic [akt_pkg::DataWidth-1:0]    prdata,
    output logic                             pready,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  akt_pkg::req_t                    req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output akt_pkg::rsp_t                    rsp_data
);

    logic [akt_pkg::AgeWidth-1:0]  age_limit_reg;
    logic [akt_pkg::AgeWidth-1:0]  age_limit_next;
    logic                          reg_sel;
    akt_pkg::chain_ctl_t           ctl;
    akt_pkg::entry_t               ent [CAPACITY];

    // register access
    assign pready  = 1'b1;
    assign reg_sel = (paddr[akt_pkg::PaddrWidth-1] == akt_pkg::RegAgeLimit);

    always_comb
    begin
        age_limit_next = age_limit_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            age_limit_next = pwdata[akt_pkg::AgeWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= akt_pkg::AgeLimitReset;
        end
        else
        begin
            age_limit_reg <= age_limit_next;
        end
    end

    assign prdata = reg_sel ?
        {{(akt_pkg::DataWidth - akt_pkg::AgeWidth){1'b0}}, age_limit_reg} : '0;

    // row of table cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        akt_pkg::entry_t right;
        logic            left_valid;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right = '0;
        end
        else
        begin : g_body
            assign right = ent[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_valid = 1'b1;
        end
        else
        begin : g_rest
            assign left_valid = ent[i-1].valid;
        end

        akt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .right      (right),
            .left_valid (left_valid),
            .ent        (ent[i])
        );
    end

    // sweep sequencer
    akt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .age_limit (age_limit_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .head      (ent[0]),
        .full      (ent[CAPACITY-1].valid),
        .ctl       (ctl)
    );

endmodule

FILE: tb/key_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_table_checker: response checker of the aging key table
// Mirrors the key table from accepted requests and register writes, and
// compares every response, field by field, with the oldest predicted command.
// ----------------------------------------------------------------------------
module key_table_checker #(
    parameter int                             CAPACITY       = 32,
    parameter logic [akt_pkg::PaddrWidth-1:0] AGE_LIMIT_ADDR = '0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [akt_pkg::PaddrWidth-1:0] paddr,
    input  logic [akt_pkg::DataWidth-1:0]  pwdata,
    input  logic [akt_pkg::DataWidth-1:0]  prdata,
    input  logic                           pready,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  akt_pkg::req_t                  req_data,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  akt_pkg::rsp_t                  rsp_data,
    output int                             mismatch_count,
    output int                             pending_count
);
    import akt_pkg::*;

    // mirrored table, kept packed in insertion order
    logic [KeyWidth-1:0] table_keys [$];
    logic [AgeWidth-1:0] table_ages [$];
    logic [AgeWidth-1:0] age_limit = AgeLimitReset;

    // indicator commands still owed by the block, oldest first
    rsp_t                expected_commands [$];

    function automatic rsp_t make_command(logic [KeyWidth-1:0] k, logic cmd, logic hit,
                                          logic drop, logic final_one);
        rsp_t c;
        c.led_key     = k;
        c.led_command = cmd;
        c.found       = hit;
        c.dropped     = drop;
        c.last        = final_one;
        return c;
    endfunction

    function automatic int locate_key(logic [KeyWidth-1:0] k);
        foreach (table_keys[i])
        begin
            if (table_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    // add: store if absent and room left, always blink unless key is zero
    function automatic void predict_add(logic [KeyWidth-1:0] k);
        logic drop;
        drop = 1'b0;
        if (k == '0)
            return;
        if (locate_key(k) < 0)
        begin
            if (table_keys.size() < CAPACITY)
            begin
                table_keys.insert(table_keys.size(), k);
                table_ages.insert(table_ages.size(), '0);
            end
            else
                drop = 1'b1;
        end
        expected_commands.insert(expected_commands.size(),
                                 make_command(k, LedBlink, 1'b0, drop, 1'b1));
    endfunction

    // remove: free the entry if present, one off command either way
    function automatic void predict_remove(logic [KeyWidth-1:0] k);
        int pos;
        pos = locate_key(k);
        if (pos >= 0)
        begin
            table_keys.delete(pos);
            table_ages.delete(pos);
        end
        expected_commands.insert(expected_commands.size(),
                                 make_command(k, LedOff, pos >= 0, 1'b0, 1'b1));
    endfunction

    // tick: age live entries, expire those at or past the limit in table order
    function automatic void predict_tick();
        logic [KeyWidth-1:0] kept_keys [$];
        logic [AgeWidth-1:0] kept_ages [$];
        logic [KeyWidth-1:0] expired [$];
        foreach (table_keys[i])
        begin
            if (table_ages[i] < age_limit)
            begin
                kept_keys.insert(kept_keys.size(), table_keys[i]);
                kept_ages.insert(kept_ages.size(), table_ages[i] + 16'd1);
            end
            else if (expired.size() < MaxResults)
                expired.insert(expired.size(), table_keys[i]);
            else
            begin
                kept_keys.insert(kept_keys.size(), table_keys[i]);
                kept_ages.insert(kept_ages.size(), table_ages[i]);
            end
        end
        foreach (expired[j])
            expected_commands.insert(expected_commands.size(),
                                     make_command(expired[j], LedOff, 1'b0, 1'b0,
                                                  j == expired.size() - 1));
        table_keys = kept_keys;
        table_ages = kept_ages;
    endfunction

    function automatic void compare_field(string name, logic [DataWidth-1:0] want,
                                          logic [DataWidth-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            table_keys.delete();
            table_ages.delete();
            expected_commands.delete();
            age_limit = AgeLimitReset;
            pending_count <= 0;
        end
        else
        begin
            // register port
            if (psel && penable && pready && paddr == AGE_LIMIT_ADDR)
            begin
                if (pwrite)
                    age_limit = pwdata[AgeWidth-1:0];
                else
                    compare_field("prdata", DataWidth'(age_limit), prdata);
            end

            // response side
            if (rsp_valid && rsp_ready)
            begin
                if (expected_commands.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, rsp_data);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_commands.pop_front();
                    compare_field("led_key", DataWidth'(want.led_key),
                                  DataWidth'(rsp_data.led_key));
                    compare_field("led_command", DataWidth'(want.led_command),
                                  DataWidth'(rsp_data.led_command));
                    compare_field("found", DataWidth'(want.found),
                                  DataWidth'(rsp_data.found));
                    compare_field("dropped", DataWidth'(want.dropped),
                                  DataWidth'(rsp_data.dropped));
                    compare_field("last", DataWidth'(want.last),
                                  DataWidth'(rsp_data.last));
                end
            end

            // request side
            if (req_valid && req_ready)
            begin
                case (req_data.func)
                    FuncAdd:    predict_add(req_data.key);
                    FuncRemove: predict_remove(req_data.key);
                    FuncTick:   predict_tick();
                    default:    ;
                endcase
            end

            pending_count <= expected_commands.size();
        end
    end

endmodule

FILE: tb/aging_key_table_with_led_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_key_table_with_led_core_test: top of the aging key table testbench
// Drives directed and random requests with random stalls on both channels,
// steps age_limit through several values and reports the checker's verdict.
// ----------------------------------------------------------------------------
module aging_key_table_with_led_core_test;
    import akt_pkg::*;

    localparam int                    CAPACITY     = 32;
    localparam int                    PhaseItems   = 75;
    localparam int                    SweepCycles  = CAPACITY + 4;
    localparam int                    CycleLimit   = 1_000_000;
    localparam logic [FuncWidth-1:0]  FuncSpare    = 2'd3;
    localparam logic [PaddrWidth-1:0] AgeLimitAddr = PaddrWidth'(4 * RegAgeLimit);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [PaddrWidth-1:0] paddr     = '0;
    logic [DataWidth-1:0]  pwdata    = '0;
    logic [DataWidth-1:0]  prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp_data;

    logic                  steady    = 1'b0;
    int                    cycle_count = 0;
    int                    mismatch_count;
    int                    pending_count;

    logic [AgeWidth-1:0]   phase_limits [6] = '{16'hFFFF, 16'd1, 16'd7, 16'd0,
                                                AgeLimitReset, 16'd3};

    always #10 clk = ~clk;

    aging_key_table_with_led_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    key_table_checker #(
        .CAPACITY       (CAPACITY),
        .AGE_LIMIT_ADDR (AgeLimitAddr)
    ) checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // response stalls, none while steady
    always @(posedge clk)
    begin
        rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("[aging_key_table_with_led_core] ERROR");
            $finish;
        end
    end

    // one request, with a random gap before it unless steady
    task automatic send_request(logic [FuncWidth-1:0] f, logic [KeyWidth-1:0] k);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 37)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_data.func <= f;
        req_data.key  <= k;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // stop requests, wait for owed commands, then let a silent sweep finish
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SweepCycles) @(posedge clk);
    endtask

    // write age_limit, then read it back
    task automatic set_age_limit(logic [AgeWidth-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AgeLimitAddr;
        pwdata  <= DataWidth'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly a small key pool so that removes hit and the table fills
    function automatic logic [KeyWidth-1:0] random_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 25)
            return KeyWidth'($urandom_range(0, 255));
        return KeyWidth'($urandom_range(1, 48));
    endfunction

    task automatic random_request(output bit counted);
        int                   roll;
        logic [FuncWidth-1:0] f;
        logic [KeyWidth-1:0]  k;
        roll = $urandom_range(0, 99);
        k    = random_key();
        if (roll < 55)
            f = FuncAdd;
        else if (roll < 67)
            f = FuncRemove;
        else if (roll < 95)
            f = FuncTick;
        else
            f = FuncSpare;
        send_request(f, k);
        counted = (f != FuncSpare) && !(f == FuncAdd && k == '0);
    endtask

    initial
    begin
        int done_items;
        bit counted;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset age limit
        send_request(FuncAdd, 8'h00);       // zero key, no command
        send_request(FuncAdd, 8'hFF);
        send_request(FuncAdd, 8'h01);
        send_request(FuncAdd, 8'hFF);       // already present
        send_request(FuncAdd, 8'h80);
        send_request(FuncRemove, 8'h55);    // absent key
        send_request(FuncRemove, 8'h00);    // zero key, absent
        send_request(FuncSpare, 8'hA5);     // unused code, ignored
        send_request(FuncTick, 8'h00);      // nothing expires
        send_request(FuncRemove, 8'hFF);
        send_request(FuncRemove, 8'hFF);    // gone now
        send_request(FuncAdd, 8'hAA);
        send_request(FuncAdd, 8'h55);
        settle();

        // directed, zero age limit: every entry expires on the next tick
        set_age_limit('0);
        send_request(FuncTick, 8'h3C);
        send_request(FuncTick, 8'hC3);      // empty table
        send_request(FuncAdd, 8'h07);
        send_request(FuncAdd, 8'h09);
        send_request(FuncTick, 8'h00);
        send_request(FuncRemove, 8'h07);
        settle();

        // random phases, one per age limit
        foreach (phase_limits[p])
        begin
            set_age_limit(phase_limits[p]);
            steady <= (phase_limits[p] == 16'd1);
            done_items = 0;
            while (done_items < PhaseItems)
            begin
                random_request(counted);
                if (counted)
                    done_items++;
            end
            settle();
        end

        if (mismatch_count == 0 && pending_count == 0)
            $display("[aging_key_table_with_led_core] OK");
        else
            $display("[aging_key_table_with_led_core] ERROR");
        $finish;
    end

endmodule
